>>> design/sfd_pkg.sv
// types, constants and helper functions shared by the flat segment detector
package sfd_pkg;

   localparam int COORD_W    = 24;
   localparam int DIFF_W     = COORD_W + 1;
   localparam int PCT_W      = 10;
   localparam int PROD_W     = 35;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 10;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_TANGENT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_EDIT    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MULTI   = 2'd2;

   // item mode codes
   localparam logic MODE_BEGIN = 1'b0;
   localparam logic MODE_POINT = 1'b1;

   localparam logic [PCT_W-1:0]  TANGENT_RESET = 10'd100;
   localparam logic [6:0]        PCT_SCALE     = 7'd100;
   // 8.0 and 10.0 in 8-bit fraction fixed point
   localparam logic [DIFF_W-1:0] NEAR_DELTA    = 25'd2048;
   localparam logic [DIFF_W-1:0] SPAN_DELTA    = 25'd2560;

   typedef logic signed [COORD_W-1:0] coord_type;

   typedef enum logic [1:0] {
      DIR_START = 2'd0,
      DIR_UP    = 2'd1,
      DIR_DOWN  = 2'd2
   } dir_type;

   typedef struct packed {
      logic      mode;
      coord_type px;
      coord_type py;
      coord_type end_x;
      coord_type end_y;
   } req_type;

   typedef struct packed {
      logic      h_found;
      coord_type h_from;
      coord_type h_to;
      coord_type h_level;
      logic      v_found;
      coord_type v_from;
      coord_type v_to;
      coord_type v_level;
      logic      conflict;
   } rsp_type;

   typedef struct packed {
      logic [PCT_W-1:0] tangent_pct;
      logic             edit_enable;
      logic             multi_master;
   } cfg_type;

   // tracker state, coordinates given along and across the tracked axis
   typedef struct packed {
      dir_type   dir;
      dir_type   first;
      logic      flat;
      logic      done;
      coord_type start_a;
      coord_type start_o;
      coord_type end_a;
      coord_type end_o;
   } axis_state_type;

   typedef struct packed {
      logic done_now;
      logic found;
      logic backward;
   } axis_event_type;

   // classified item between front and back
   typedef struct packed {
      logic      h_found;
      logic      v_found;
      logic      conflict;
      coord_type h_run_x;
      coord_type h_run_y;
      coord_type v_run_x;
      coord_type v_run_y;
      coord_type end_x;
      coord_type end_y;
   } mid_type;

   localparam axis_state_type AXIS_RESET = '{
      dir: DIR_START, first: DIR_START, flat: 1'b0, done: 1'b0,
      start_a: '0, start_o: '0, end_a: '0, end_o: '0
   };

   function automatic logic signed [DIFF_W-1:0] signed_diff(input coord_type a,
                                                            input coord_type b);
      return {a[COORD_W-1], a} - {b[COORD_W-1], b};
   endfunction

   function automatic logic [DIFF_W-1:0] abs_diff(input coord_type a, input coord_type b);
      logic signed [DIFF_W-1:0] d;
      d = signed_diff(a, b);
      return d[DIFF_W-1] ? $unsigned(-d) : $unsigned(d);
   endfunction

   // (a + b) / 2 with truncation toward zero
   function automatic coord_type mid_level(input coord_type a, input coord_type b);
      logic signed [DIFF_W-1:0] s;
      s = {a[COORD_W-1], a} + {b[COORD_W-1], b};
      s = s + DIFF_W'(s[DIFF_W-1]);
      return s[DIFF_W-1:1];
   endfunction

endpackage

>>> design/sfd_fifo.sv
// small register queue with full and empty flags
module sfd_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

>>> design/sfd_axis.sv
// direction and flat-run tracker for one axis, with the segment judgement
module sfd_axis (
   input  sfd_pkg::axis_state_type     state_in,
   input  sfd_pkg::coord_type          cur_a,
   input  sfd_pkg::coord_type          cur_o,
   input  sfd_pkg::coord_type          prev_a,
   input  sfd_pkg::coord_type          prev_o,
   input  sfd_pkg::coord_type          curve_start_a,
   input  sfd_pkg::coord_type          curve_end_a,
   input  logic [sfd_pkg::PCT_W-1:0]   tangent_pct,
   output sfd_pkg::axis_state_type     state_out,
   output sfd_pkg::axis_event_type     evt
);
   import sfd_pkg::*;

   logic [DIFF_W-1:0] mag_n, mag_d;
   logic [PROD_W-1:0] lhs, rhs;
   dir_type           want;
   axis_state_type    turned;
   logic              done_now;
   logic              near_ends, backward, span_ok;

   assign mag_n = abs_diff(cur_a, prev_a);
   assign mag_d = abs_diff(cur_o, prev_o);
   assign lhs   = PROD_W'(mag_n) * PROD_W'(PCT_SCALE);
   assign rhs   = PROD_W'(mag_d) * PROD_W'(tangent_pct);

   always_comb begin
      priority if (cur_a > prev_a) begin
         want = DIR_UP;
      end else if (cur_a < prev_a) begin
         want = DIR_DOWN;
      end else begin
         want = DIR_START;
      end
   end

   // direction change first
   always_comb begin
      turned = state_in;
      if (want != DIR_START && state_in.dir != want) begin
         if (state_in.dir == DIR_START) begin
            turned.dir   = want;
            turned.first = want;
         end else begin
            if (state_in.first == want) begin
               turned.end_a = prev_a;
               turned.end_o = prev_o;
            end else if (!state_in.flat) begin
               turned.start_a = prev_a;
               turned.start_o = prev_o;
               turned.flat    = 1'b1;
            end
            turned.dir = want;
         end
      end
   end

   // then the slope test opens or closes the run
   always_comb begin
      state_out = turned;
      done_now  = 1'b0;
      if (!turned.flat) begin
         if (lhs < rhs) begin
            state_out.flat    = 1'b1;
            state_out.start_a = prev_a;
            state_out.start_o = prev_o;
         end
      end else if (turned.dir == turned.first && lhs > rhs) begin
         state_out.end_a = prev_a;
         state_out.end_o = prev_o;
         state_out.done  = 1'b1;
         done_now        = 1'b1;
      end
   end

   // a run can only close if it was already open, so its start is the
   // one after the direction step and its end is the previous point
   assign near_ends = (abs_diff(turned.start_a, curve_start_a) <= NEAR_DELTA) ||
                      (abs_diff(curve_end_a, prev_a) <= NEAR_DELTA);
   assign backward  = (turned.first == DIR_UP &&
                       signed_diff(turned.start_a, prev_a) > $signed(NEAR_DELTA)) ||
                      (turned.first == DIR_DOWN &&
                       signed_diff(prev_a, turned.start_a) > $signed(NEAR_DELTA));
   assign span_ok   = abs_diff(turned.start_o, prev_o) > SPAN_DELTA;

   assign evt.done_now = done_now;
   assign evt.backward = done_now & ~near_ends & backward;
   assign evt.found    = done_now & ~near_ends & ~backward & span_ok;

endmodule

>>> design/sfd_front.sv
// front end: accepts items, runs both trackers and classifies the result
module sfd_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  sfd_pkg::req_type req_data,
   input  sfd_pkg::cfg_type cfg,
   input  logic             mid_full,
   output logic             mid_push,
   output sfd_pkg::mid_type mid_data
);
   import sfd_pkg::*;

   axis_state_type y_st_ff, y_st_in, y_next;
   axis_state_type x_st_ff, x_st_in, x_next;
   axis_event_type y_evt, x_evt;
   coord_type      cs_x_ff, cs_x_in, cs_y_ff, cs_y_in;
   coord_type      ce_x_ff, ce_x_in, ce_y_ff, ce_y_in;
   coord_type      prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic           accept, point;
   logic           y_run, x_run, y_stop, x_stop;

   sfd_axis u_axis_y (
      .state_in      (y_st_ff),
      .cur_a         (req_data.py),
      .cur_o         (req_data.px),
      .prev_a        (prev_y_ff),
      .prev_o        (prev_x_ff),
      .curve_start_a (cs_y_ff),
      .curve_end_a   (ce_y_ff),
      .tangent_pct   (cfg.tangent_pct),
      .state_out     (y_next),
      .evt           (y_evt)
   );

   sfd_axis u_axis_x (
      .state_in      (x_st_ff),
      .cur_a         (req_data.px),
      .cur_o         (req_data.py),
      .prev_a        (prev_x_ff),
      .prev_o        (prev_y_ff),
      .curve_start_a (cs_x_ff),
      .curve_end_a   (ce_x_ff),
      .tangent_pct   (cfg.tangent_pct),
      .state_out     (x_next),
      .evt           (x_evt)
   );

   assign req_full = mid_full;
   assign accept   = req_push & ~mid_full;
   assign point    = (req_data.mode == MODE_POINT);

   // a backward run on y keeps the x tracker from running
   assign y_run  = point & ~y_st_ff.done;
   assign y_stop = y_run & y_evt.backward;
   assign x_run  = point & ~y_stop & ~x_st_ff.done;
   assign x_stop = x_run & x_evt.backward;

   always_comb begin
      y_st_in   = y_st_ff;
      x_st_in   = x_st_ff;
      cs_x_in   = cs_x_ff;
      cs_y_in   = cs_y_ff;
      ce_x_in   = ce_x_ff;
      ce_y_in   = ce_y_ff;
      prev_x_in = prev_x_ff;
      prev_y_in = prev_y_ff;
      if (accept) begin
         if (!point) begin
            y_st_in.dir   = DIR_START;
            y_st_in.first = DIR_START;
            y_st_in.flat  = 1'b0;
            y_st_in.done  = 1'b0;
            x_st_in.dir   = DIR_START;
            x_st_in.first = DIR_START;
            x_st_in.flat  = 1'b0;
            x_st_in.done  = 1'b0;
            cs_x_in       = req_data.px;
            cs_y_in       = req_data.py;
            ce_x_in       = req_data.end_x;
            ce_y_in       = req_data.end_y;
            prev_x_in     = req_data.px;
            prev_y_in     = req_data.py;
         end else begin
            if (y_run) begin
               y_st_in = y_next;
            end
            if (x_run) begin
               x_st_in = x_next;
            end
            if (!(y_stop || x_stop)) begin
               prev_x_in = req_data.px;
               prev_y_in = req_data.py;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         y_st_ff   <= AXIS_RESET;
         x_st_ff   <= AXIS_RESET;
         cs_x_ff   <= '0;
         cs_y_ff   <= '0;
         ce_x_ff   <= '0;
         ce_y_ff   <= '0;
         prev_x_ff <= '0;
         prev_y_ff <= '0;
      end else begin
         y_st_ff   <= y_st_in;
         x_st_ff   <= x_st_in;
         cs_x_ff   <= cs_x_in;
         cs_y_ff   <= cs_y_in;
         ce_x_ff   <= ce_x_in;
         ce_y_ff   <= ce_y_in;
         prev_x_ff <= prev_x_in;
         prev_y_ff <= prev_y_in;
      end
   end

   assign mid_push          = accept;
   assign mid_data.h_found  = y_run & y_evt.found;
   assign mid_data.v_found  = x_run & x_evt.found;
   assign mid_data.conflict = (y_stop | x_stop) & cfg.edit_enable & ~cfg.multi_master;
   // y tracker keeps y along, x across; x tracker the other way round
   assign mid_data.h_run_x  = y_next.start_o;
   assign mid_data.h_run_y  = y_next.start_a;
   assign mid_data.v_run_x  = x_next.start_a;
   assign mid_data.v_run_y  = x_next.start_o;
   assign mid_data.end_x    = prev_x_ff;
   assign mid_data.end_y    = prev_y_ff;

endmodule

>>> design/sfd_back.sv
// back end: turns classified items into result transactions
module sfd_back (
   input  logic             mid_empty,
   input  sfd_pkg::mid_type mid_data,
   output logic             mid_pop,
   input  logic             multi_master,
   input  logic             rsp_full,
   output logic             rsp_push,
   output sfd_pkg::rsp_type rsp_wdata
);
   import sfd_pkg::*;

   assign mid_pop  = ~mid_empty & ~rsp_full;
   assign rsp_push = mid_pop;

   always_comb begin
      rsp_wdata          = '0;
      rsp_wdata.conflict = mid_data.conflict;
      if (mid_data.h_found) begin
         rsp_wdata.h_found = 1'b1;
         rsp_wdata.h_level = mid_level(mid_data.h_run_y, mid_data.end_y);
         if (!multi_master) begin
            rsp_wdata.h_from = mid_data.h_run_x;
            rsp_wdata.h_to   = mid_data.end_x;
         end
      end
      if (mid_data.v_found) begin
         rsp_wdata.v_found = 1'b1;
         rsp_wdata.v_level = mid_level(mid_data.v_run_x, mid_data.end_x);
         if (!multi_master) begin
            rsp_wdata.v_from = mid_data.v_run_y;
            rsp_wdata.v_to   = mid_data.end_y;
         end
      end
   end

endmodule

>>> design/s_curve_flat_segment_detector.sv
// top level of the flat segment detector for flattened s-shaped curves
//
// usage
//  - req side looks like a queue: drive req_data and raise req_push; the
//    transaction is taken at a clock edge where req_full is low. mode 0
//    begins a curve (start and end point), mode 1 is a flattened point
//  - rsp side looks like a queue: while rsp_empty is low the oldest result
//    sits on rsp_data; pulse rsp_pop to take it. every item gives one result
//  - csr side: csr_index / csr_wdata written when csr_valid is high, ready
//    is always high. write only while the block is idle
//  - throughput: one item per cycle while the classify queue has room. the
//    trackers update their state in the same cycle an item is taken, so the next point follows at once
//  - a taken item's result goes into the classify queue at the edge that
//    takes the item; the back end moves it into the result queue, where it
//    shows on rsp_data, once the result queue has room
//  - a stalled receiver fills the result queue and then the classify queue;
//    req_full rises when the classify queue is full, nothing is dropped
//  - reset (synchronous, active high) empties both queues, clears the
//    trackers, endpoints and previous point, and loads register defaults
//    (tangent 100 percent, edit and multi-master off)
module s_curve_flat_segment_detector #(
   parameter int MID_DEPTH = 4,
   parameter int RSP_DEPTH = 2
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_push,
   output logic                              req_full,
   input  sfd_pkg::req_type                  req_data,
   input  logic                              rsp_pop,
   output logic                              rsp_empty,
   output sfd_pkg::rsp_type                  rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [sfd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [sfd_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import sfd_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    mid_push, mid_full, mid_pop, mid_empty;
   mid_type mid_wdata, mid_rdata;
   logic    rsp_push, rsp_full;
   rsp_type rsp_wdata;

   // configuration registers, writes are never stalled
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_TANGENT: cfg_in.tangent_pct  = csr_wdata[PCT_W-1:0];
            CSR_EDIT:    cfg_in.edit_enable  = csr_wdata[0];
            CSR_MULTI:   cfg_in.multi_master = csr_wdata[0];
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tangent_pct  <= TANGENT_RESET;
         cfg_ff.edit_enable  <= 1'b0;
         cfg_ff.multi_master <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: trackers and classification
   sfd_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .cfg      (cfg_ff),
      .mid_full (mid_full),
      .mid_push (mid_push),
      .mid_data (mid_wdata)
   );

   // queue between front and back
   sfd_fifo #(
      .WIDTH ($bits(mid_type)),
      .DEPTH (MID_DEPTH)
   ) u_mid_fifo (
      .clock (clock),
      .reset (reset),
      .push  (mid_push),
      .wdata (mid_wdata),
      .full  (mid_full),
      .pop   (mid_pop),
      .rdata (mid_rdata),
      .empty (mid_empty)
   );

   // back: segment span and level formatting
   sfd_back u_back (
      .mid_empty    (mid_empty),
      .mid_data     (mid_rdata),
      .mid_pop      (mid_pop),
      .multi_master (cfg_ff.multi_master),
      .rsp_full     (rsp_full),
      .rsp_push     (rsp_push),
      .rsp_wdata    (rsp_wdata)
   );

   // result queue, decouples the receiver from the back end
   sfd_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_fifo (
      .clock (clock),
      .reset (reset),
      .push  (rsp_push),
      .wdata (rsp_wdata),
      .full  (rsp_full),
      .pop   (rsp_pop),
      .rdata (rsp_data),
      .empty (rsp_empty)
   );

endmodule

>>> design/sfd_checker.sv
// port-level assertions for the flat segment detector, bound to the top level
module sfd_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_push,
   input logic             req_full,
   input logic             rsp_pop,
   input logic             rsp_empty,
   input sfd_pkg::rsp_type rsp_data
);
   import sfd_pkg::*;

   // reset leaves both sides empty and open
   a_reset_clears: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("queues not cleared by reset");

   // a taken item is followed by a result waiting on the result side
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_push && !req_full) |=> ##1 !rsp_empty)
      else $error("result missing two cycles after accept");

   // no horizontal segment means zero span and level
   a_h_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_data.h_found) |->
         (rsp_data.h_from == '0 && rsp_data.h_to == '0 && rsp_data.h_level == '0))
      else $error("horizontal fields set without a segment");

   // no vertical segment means zero span and level
   a_v_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_data.v_found) |->
         (rsp_data.v_from == '0 && rsp_data.v_to == '0 && rsp_data.v_level == '0))
      else $error("vertical fields set without a segment");

   // a waiting result holds until popped
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)))
      else $error("waiting result changed before pop");

endmodule

bind s_curve_flat_segment_detector sfd_checker u_sfd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_push  (req_push),
   .req_full  (req_full),
   .rsp_pop   (rsp_pop),
   .rsp_empty (rsp_empty),
   .rsp_data  (rsp_data)
);

>>> tb/sfd_segment_checker.sv
// segment checker for the flat segment detector: predicts each result and compares
`timescale 1ns / 100ps

module sfd_segment_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_push,
   input  logic                           req_full,
   input  sfd_pkg::req_type               req_data,
   input  logic                           rsp_pop,
   input  logic                           rsp_empty,
   input  sfd_pkg::rsp_type               rsp_data,
   input  logic                           csr_valid,
   input  logic                           csr_ready,
   input  logic [sfd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sfd_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                             reports_due,
   output int                             mismatch_count
);

   import sfd_pkg::*;

   typedef enum logic [1:0] {
      RUN_NONE,
      RUN_FOUND,
      RUN_BACKWARD
   } run_verdict_type;

   localparam int TRK_H = 0;
   localparam int TRK_V = 1;
   localparam int RUN_X = 0;
   localparam int RUN_Y = 1;

   logic [PCT_W-1:0] tangent_pct;
   logic             edit_on;
   logic             multi_on;

   dir_type   trk_dir   [2];
   dir_type   trk_first [2];
   logic      trk_flat  [2];
   logic      trk_done  [2];
   // per tracker: start x, start y, end x, end y of the flat run
   coord_type trk_run   [2][4];
   coord_type curve_end [4];
   coord_type prev_x;
   coord_type prev_y;

   rsp_type segment_reports_q [$];
   int      errors = 0;
   int      results_seen = 0;

   function automatic longint magnitude(input longint v);
      return (v < 0) ? -v : v;
   endfunction

   // n is the step along the tracked axis, d the step across it
   function automatic void follow_axis(input int t, input longint n, input longint d);
      dir_type want;
      longint  lhs;
      longint  rhs;
      want = DIR_START;
      lhs = magnitude(n) * longint'(PCT_SCALE);
      rhs = magnitude(d) * longint'(tangent_pct);
      if (n > 0) begin
         want = DIR_UP;
      end else if (n < 0) begin
         want = DIR_DOWN;
      end
      if (want != DIR_START && trk_dir[t] != want) begin
         if (trk_dir[t] == DIR_START) begin
            trk_dir[t] = want;
            trk_first[t] = want;
         end else begin
            if (trk_first[t] == want) begin
               trk_run[t][2] = prev_x;
               trk_run[t][3] = prev_y;
            end else if (!trk_flat[t]) begin
               trk_run[t][0] = prev_x;
               trk_run[t][1] = prev_y;
               trk_flat[t] = 1'b1;
            end
            trk_dir[t] = want;
         end
      end
      if (!trk_flat[t]) begin
         if (lhs < rhs) begin
            trk_flat[t] = 1'b1;
            trk_run[t][0] = prev_x;
            trk_run[t][1] = prev_y;
         end
      end else if (trk_dir[t] == trk_first[t] && lhs > rhs) begin
         trk_run[t][2] = prev_x;
         trk_run[t][3] = prev_y;
         trk_done[t] = 1'b1;
      end
   endfunction

   // k picks the tracked axis inside a coordinate pair
   function automatic run_verdict_type judge_run(input int t, input int k,
                                                 output longint from_v,
                                                 output longint to_v,
                                                 output longint level_v);
      longint a0;
      longint a1;
      longint o0;
      longint o1;
      int     o;
      o = 1 - k;
      a0 = longint'(trk_run[t][k]);
      a1 = longint'(trk_run[t][k+2]);
      o0 = longint'(trk_run[t][o]);
      o1 = longint'(trk_run[t][o+2]);
      from_v = 0;
      to_v = 0;
      level_v = 0;
      if (magnitude(a0 - longint'(curve_end[k])) <= longint'(NEAR_DELTA))
         return RUN_NONE;
      if (magnitude(longint'(curve_end[k+2]) - a1) <= longint'(NEAR_DELTA))
         return RUN_NONE;
      if ((trk_first[t] == DIR_UP && a0 - a1 > longint'(NEAR_DELTA)) ||
          (trk_first[t] == DIR_DOWN && a1 - a0 > longint'(NEAR_DELTA)))
         return RUN_BACKWARD;
      if (magnitude(o0 - o1) <= longint'(SPAN_DELTA))
         return RUN_NONE;
      level_v = (a0 + a1) / 2;
      if (!multi_on) begin
         from_v = o0;
         to_v = o1;
      end
      return RUN_FOUND;
   endfunction

   function automatic rsp_type predict_segments(input req_type item);
      rsp_type         seg;
      longint          x;
      longint          y;
      longint          dx;
      longint          dy;
      longint          f;
      longint          tv;
      longint          l;
      logic            halted;
      run_verdict_type verdict;
      int              t;
      seg = '0;
      halted = 1'b0;
      x = longint'(item.px);
      y = longint'(item.py);
      if (item.mode == MODE_BEGIN) begin
         // run coordinates survive a new curve, everything else restarts
         for (t = 0; t < 2; t++) begin
            trk_dir[t] = DIR_START;
            trk_first[t] = DIR_START;
            trk_flat[t] = 1'b0;
            trk_done[t] = 1'b0;
         end
         curve_end[0] = item.px;
         curve_end[1] = item.py;
         curve_end[2] = item.end_x;
         curve_end[3] = item.end_y;
         prev_x = item.px;
         prev_y = item.py;
      end else begin
         dx = x - longint'(prev_x);
         dy = y - longint'(prev_y);
         if (!trk_done[TRK_H]) begin
            follow_axis(TRK_H, dy, dx);
            if (trk_done[TRK_H] && trk_flat[TRK_H]) begin
               verdict = judge_run(TRK_H, RUN_Y, f, tv, l);
               if (verdict == RUN_BACKWARD) begin
                  halted = 1'b1;
                  seg.conflict = edit_on & ~multi_on;
               end else if (verdict == RUN_FOUND) begin
                  seg.h_found = 1'b1;
                  seg.h_from = f[COORD_W-1:0];
                  seg.h_to = tv[COORD_W-1:0];
                  seg.h_level = l[COORD_W-1:0];
               end
            end
         end
         // a backward horizontal run ends the item before the x tracker
         if (!halted && !trk_done[TRK_V]) begin
            follow_axis(TRK_V, dx, dy);
            if (trk_done[TRK_V] && trk_flat[TRK_V]) begin
               verdict = judge_run(TRK_V, RUN_X, f, tv, l);
               if (verdict == RUN_BACKWARD) begin
                  halted = 1'b1;
                  seg.conflict = edit_on & ~multi_on;
               end else if (verdict == RUN_FOUND) begin
                  seg.v_found = 1'b1;
                  seg.v_from = f[COORD_W-1:0];
                  seg.v_to = tv[COORD_W-1:0];
                  seg.v_level = l[COORD_W-1:0];
               end
            end
         end
         if (!halted) begin
            prev_x = item.px;
            prev_y = item.py;
         end
      end
      return seg;
   endfunction

   task automatic report_failure(input string msg);
      $display("result %0d: %s", results_seen, msg);
      errors++;
   endtask

   task automatic check_field(input string name, input logic [COORD_W-1:0] got,
                              input logic [COORD_W-1:0] want);
      if (got !== want)
         report_failure($sformatf("%s is %h, expected %h", name, got, want));
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      int      i;
      if (reset) begin
         tangent_pct = TANGENT_RESET;
         edit_on = 1'b0;
         multi_on = 1'b0;
         for (i = 0; i < 2; i++) begin
            trk_dir[i] = DIR_START;
            trk_first[i] = DIR_START;
            trk_flat[i] = 1'b0;
            trk_done[i] = 1'b0;
         end
         for (i = 0; i < 4; i++) begin
            trk_run[TRK_H][i] = '0;
            trk_run[TRK_V][i] = '0;
            curve_end[i] = '0;
         end
         prev_x = '0;
         prev_y = '0;
         segment_reports_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_TANGENT: tangent_pct = csr_wdata[PCT_W-1:0];
               CSR_EDIT:    edit_on = csr_wdata[0];
               CSR_MULTI:   multi_on = csr_wdata[0];
               default: ;
            endcase
         end
         if (rsp_pop && !rsp_empty) begin
            if (segment_reports_q.size() == 0) begin
               report_failure("result transaction with no item waiting");
            end else begin
               want = segment_reports_q.pop_front();
               check_field("h_found", COORD_W'(rsp_data.h_found), COORD_W'(want.h_found));
               check_field("h_from", rsp_data.h_from, want.h_from);
               check_field("h_to", rsp_data.h_to, want.h_to);
               check_field("h_level", rsp_data.h_level, want.h_level);
               check_field("v_found", COORD_W'(rsp_data.v_found), COORD_W'(want.v_found));
               check_field("v_from", rsp_data.v_from, want.v_from);
               check_field("v_to", rsp_data.v_to, want.v_to);
               check_field("v_level", rsp_data.v_level, want.v_level);
               check_field("conflict", COORD_W'(rsp_data.conflict),
                           COORD_W'(want.conflict));
            end
            results_seen++;
         end
         if (req_push && !req_full)
            segment_reports_q.push_back(predict_segments(req_data));
      end
      reports_due <= segment_reports_q.size();
      mismatch_count <= errors;
   end

endmodule

>>> tb/s_curve_flat_segment_detector_tb.sv
// testbench top for the flat segment detector: stimulus, idling and the verdict
`timescale 1ns / 100ps

module s_curve_flat_segment_detector_tb;

   import sfd_pkg::*;

   localparam int     CYCLE_LIMIT  = 200000;
   localparam int     SETTLE_CYCLES = 8;
   localparam int     PHASE_ITEMS  = 60;
   localparam int     RANDOM_PHASES = 8;
   localparam longint UNIT = 256;           // 1.0 in 8-bit fraction fixed point
   localparam longint COORD_MAX = 8388607;
   localparam longint COORD_MIN = -8388608;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_push = 1'b0;
   req_type               req_data = '0;
   logic                  rsp_pop = 1'b0;
   logic                  csr_valid = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_TANGENT;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   logic    req_full;
   logic    rsp_empty;
   rsp_type rsp_data;
   logic    csr_ready;

   int reports_due;
   int mismatch_count;
   int cycle_count = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;

   always #2 clock = ~clock;

   s_curve_flat_segment_detector dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   sfd_segment_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_data       (req_data),
      .rsp_pop        (rsp_pop),
      .rsp_empty      (rsp_empty),
      .rsp_data       (rsp_data),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .reports_due    (reports_due),
      .mismatch_count (mismatch_count)
   );

   // receiver: pop is redrawn every cycle, high unless this cycle stalls
   always @(posedge clock) begin
      rsp_pop <= ($urandom_range(99) >= recv_stall_pct);
   end

   // watchdog against a hung handshake or a lost result
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // push one transaction, idling first if the sender is in an idle phase;
   // push stays high on return so back-to-back items need no gap
   task automatic send_item(input req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (req_full)
         @(posedge clock);
   endtask

   task automatic send_pt(input logic mode, input longint x, input longint y,
                          input longint ex, input longint ey);
      req_type item;
      item.mode = mode;
      item.px = x[COORD_W-1:0];
      item.py = y[COORD_W-1:0];
      item.end_x = ex[COORD_W-1:0];
      item.end_y = ey[COORD_W-1:0];
      send_item(item);
   endtask

   // stop sending and wait until every predicted result has been popped;
   // the first edge lets the checker's count catch up with the last push
   task automatic wait_results();
      req_push <= 1'b0;
      @(posedge clock);
      while (reports_due != 0)
         @(posedge clock);
   endtask

   // valid stays high on return so writes can follow back to back
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
   endtask

   task automatic set_config(input int pct, input logic edit, input logic multi);
      write_reg(CSR_TANGENT, pct[CSR_DATA_W-1:0]);
      write_reg(CSR_EDIT, CSR_DATA_W'(edit));
      write_reg(CSR_MULTI, CSR_DATA_W'(multi));
      csr_valid <= 1'b0;
   endtask

   // a well-formed curve: begin item, then points that alternate steep and
   // shallow stretches in a chosen direction, with the odd reversal and jump
   task automatic send_random_curve(output int count);
      longint px_q [$];
      longint py_q [$];
      longint x;
      longint y;
      longint x0;
      longint y0;
      longint ex;
      longint ey;
      longint ydir;
      longint xdir;
      longint big;
      longint nudge;
      int     n;
      int     i;
      int     kind;
      x0 = longint'($urandom_range(1 << 23)) - (1 << 22);
      y0 = longint'($urandom_range(1 << 23)) - (1 << 22);
      ydir = $urandom_range(1) ? longint'(1) : longint'(-1);
      xdir = $urandom_range(1) ? longint'(1) : longint'(-1);
      n = int'($urandom_range(16, 4));
      x = x0;
      y = y0;
      for (i = 0; i < n; i++) begin
         big = longint'($urandom_range(8192, 1024));
         nudge = longint'($urandom_range(1024)) - 512;
         kind = int'($urandom_range(9));
         if (kind < 4) begin
            // steep along y
            y = y + ydir * big;
            x = x + nudge;
         end else if (kind < 8) begin
            // shallow, mostly along x
            x = x + xdir * big;
            y = y + nudge;
         end else if (kind == 8) begin
            // turn back on y
            y = y - ydir * big;
            x = x + nudge;
         end else begin
            x = x + longint'($urandom_range(16384)) - 8192;
            y = y + longint'($urandom_range(16384)) - 8192;
         end
         px_q.push_back(x);
         py_q.push_back(y);
      end
      ex = x;
      ey = y;
      if ($urandom_range(3) == 0) begin
         ex = ex + longint'($urandom_range(8192)) - 4096;
         ey = ey + longint'($urandom_range(8192)) - 4096;
      end
      send_pt(MODE_BEGIN, x0, y0, ex, ey);
      // end fields of a point are don't-care, so fill them with noise
      for (i = 0; i < n; i++)
         send_pt(MODE_POINT, px_q[i], py_q[i], longint'($urandom()), longint'($urandom()));
      count = n + 1;
   endtask

   task automatic send_noise();
      req_type item;
      item.mode = 1'($urandom_range(1));
      item.px = COORD_W'($urandom());
      item.py = COORD_W'($urandom());
      item.end_x = COORD_W'($urandom());
      item.end_y = COORD_W'($urandom());
      send_item(item);
   endtask

   // s curve with a clean horizontal shelf between two steep climbs
   task automatic send_shelf_curve();
      send_pt(MODE_BEGIN, 0, 0, 0, 100 * UNIT);
      send_pt(MODE_POINT, 0, 20 * UNIT, 0, 0);
      send_pt(MODE_POINT, 5 * UNIT, 21 * UNIT, 0, 0);
      send_pt(MODE_POINT, 20 * UNIT, 22 * UNIT, 0, 0);
      send_pt(MODE_POINT, 20 * UNIT, 60 * UNIT, 0, 0);
      send_pt(MODE_POINT, 20 * UNIT, 100 * UNIT, 0, 0);
   endtask

   initial begin : stimulus
      int phase;
      int sent;
      int n;
      int pct;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // point before any curve has begun, then curve and point at the extremes
      send_pt(MODE_POINT, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN);
      send_pt(MODE_BEGIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN);
      send_pt(MODE_POINT, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX);

      // horizontal segment under the reset settings
      send_shelf_curve();

      // backward shelf with edit on: conflict, and the previous point holds
      // for the point that follows
      wait_results();
      set_config(100, 1'b1, 1'b0);
      send_pt(MODE_BEGIN, 0, 0, 0, 100 * UNIT);
      send_pt(MODE_POINT, 0, 40 * UNIT, 0, 0);
      send_pt(MODE_POINT, 10 * UNIT, 40 * UNIT + UNIT / 2, 0, 0);
      send_pt(MODE_POINT, 10 * UNIT, 30 * UNIT, 0, 0);
      send_pt(MODE_POINT, 20 * UNIT, 30 * UNIT + UNIT / 2, 0, 0);
      send_pt(MODE_POINT, 20 * UNIT, 80 * UNIT, 0, 0);
      send_pt(MODE_POINT, 20 * UNIT, 100 * UNIT, 0, 0);

      // multi-master: level only, from and to forced to zero
      wait_results();
      set_config(100, 1'b1, 1'b1);
      send_shelf_curve();

      // random phases, each with its own settings and idling pattern;
      // draining before every phase also makes the sender wait for all results
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_results();
         case (phase)
            0:       pct = 0;
            1:       pct = 1023;
            2:       pct = 100;
            3:       pct = 1000;
            4:       pct = 1;
            default: pct = $urandom_range(1023);
         endcase
         set_config(pct, (phase % 3) != 2, (phase % 3) == 2);
         case (phase % 4)
            0: begin
               send_idle_pct = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 60;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               recv_stall_pct = 60;
            end
            default: begin
               send_idle_pct = 37;
               recv_stall_pct = 37;
            end
         endcase
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            if ($urandom_range(4) == 0) begin
               send_noise();
               sent++;
            end else begin
               send_random_curve(n);
               sent += n;
            end
         end
      end

      wait_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
